@@ src/tchp_pkg.sv @@
// Package for the texture container header parser.
// Holds shared constants, command and status codes, bus structs and helpers.
// No dependencies.
package tchp_pkg;

  localparam int unsigned MAX_LEVELS_DEF = 16;
  localparam int unsigned HDR_BYTES      = 80;
  localparam int unsigned HDR_WORDS      = 20;
  localparam int unsigned ENTRY_BYTES    = 24;
  localparam int unsigned BATCH          = 16;
  localparam int unsigned CMD_DEPTH      = 2;
  localparam int unsigned LVL_IDX_W      = 5;

  localparam logic [31:0] FMT_BC_FIRST   = 32'd131;
  localparam logic [31:0] FMT_BC_LAST    = 32'd146;
  localparam logic [31:0] FMT_BC_8B_LAST = 32'd134;
  localparam logic [31:0] FMT_BC_8B_A    = 32'd139;
  localparam logic [31:0] FMT_BC_8B_B    = 32'd140;

  localparam logic [95:0] MAGIC = {8'h0A, 8'h1A, 8'h0A, 8'h0D, 8'hBB, 8'h30,
                                   8'h32, 8'h20, 8'h58, 8'h54, 8'h4B, 8'hAB};

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SMALL      = 4'd1,
    ST_MAGIC      = 4'd2,
    ST_DIMS       = 4'd3,
    ST_LAYOUT     = 4'd4,
    ST_SUPERCOMP  = 4'd5,
    ST_FORMAT     = 4'd6,
    ST_INDEX      = 4'd7,
    ST_LEVELS     = 4'd8,
    ST_DATASTART  = 4'd9,
    ST_SHORT      = 4'd10,
    ST_BOUNDS     = 4'd11
  } status_e;

  typedef enum logic [1:0] {
    CMD_ERR    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_CONT   = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic [31:0] size;
    logic [31:0] vk_format;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] level_count;
    logic [31:0] dfd_off;
    logic [31:0] dfd_len;
    logic [31:0] kvd_off;
    logic [31:0] kvd_len;
    logic [63:0] sgd_off;
    logic [63:0] sgd_len;
  } hdr_t;

  typedef struct packed {
    logic                 off_we;
    logic                 len_we;
    logic [LVL_IDX_W-1:0] addr;
    logic [63:0]          data;
  } lvl_wr_t;

  typedef struct packed {
    logic idle;
    logic hold;
  } back_stat_t;

  function automatic logic [2:0] block_shift(logic [31:0] f);
    logic [2:0] s;
    if (f < FMT_BC_FIRST || f > FMT_BC_LAST) begin
      s = 3'd0;
    end else if (f <= FMT_BC_8B_LAST || f == FMT_BC_8B_A || f == FMT_BC_8B_B) begin
      s = 3'd3;
    end else begin
      s = 3'd4;
    end
    return s;
  endfunction

  function automatic logic [31:0] dim_at(logic [31:0] d, logic [4:0] m);
    logic [31:0] v;
    v = d >> m;
    return (v == 32'd0) ? 32'd1 : v;
  endfunction

endpackage

@@ src/tchp_if.sv @@
// Handshake channels of the texture container header parser.
// Input byte channel and output record channel; no dependencies.
interface tchp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_req;
  logic [31:0] file_size;
  modport source (output valid, data_byte, start_req, file_size, input ready);
  modport sink   (input valid, data_byte, start_req, file_size, output ready);
endinterface

interface tchp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [4:0]  mip;
  logic [31:0] abs_offset;
  logic [31:0] byte_length;
  logic [31:0] level_width;
  logic [31:0] level_height;
  logic [31:0] pixel_format;
  logic        last;
  modport source (output valid, status, mip, abs_offset, byte_length, level_width,
                  level_height, pixel_format, last, input ready);
  modport sink   (input valid, status, mip, abs_offset, byte_length, level_width,
                  level_height, pixel_format, last, output ready);
endinterface

@@ src/tchp_cmd_fifo.sv @@
// Command queue between the byte front end and the record back end.
// Depends on tchp_pkg.
module tchp_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tchp_pkg::cmd_t data_i,
  input  logic          pop_i,
  output tchp_pkg::cmd_t data_o,
  output logic          empty_o,
  output logic          full_o
);
  import tchp_pkg::*;

  localparam int unsigned PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem_q [CMD_DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(CMD_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(CMD_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(CMD_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

@@ src/tchp_front.sv @@
// Front end: accepts file bytes, stores header words and level index entries,
// runs header checks and issues commands to the back end. Depends on tchp_pkg and tchp_if.
module tchp_front #(
  parameter int unsigned MAX_LEVELS = tchp_pkg::MAX_LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tchp_in_if.sink              in_i,
  output logic                 cmd_push_o,
  output tchp_pkg::cmd_t       cmd_o,
  input  logic                 cmd_full_i,
  input  logic                 cmd_empty_i,
  input  tchp_pkg::back_stat_t stat_i,
  output tchp_pkg::hdr_t       hdr_o,
  output tchp_pkg::lvl_wr_t    wr_o
);
  import tchp_pkg::*;

  localparam int unsigned LW    = $clog2(MAX_LEVELS + 1);
  localparam int unsigned POS_W = $clog2(HDR_BYTES + ENTRY_BYTES * MAX_LEVELS + 1);
  localparam int unsigned KW    = $clog2(ENTRY_BYTES);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_LOAD = 4'b0010,
    F_WAIT = 4'b0100,
    F_EMIT = 4'b1000
  } fst_e;

  fst_e             st_q, st_d;
  logic [POS_W-1:0] pos_q, pos_d, end_q;
  logic [KW-1:0]    k_q, k_d;
  logic [LVL_IDX_W-1:0] ent_q, ent_d;
  logic [55:0]      sh_q;
  logic [31:0]      size_q;
  logic [31:0]      hdr_q [HDR_WORDS];

  logic             acc, start, too_small, load_en, in_hdr, hdr_end, hdr_bad;
  logic [POS_W-1:0] p, pnext, end_val;
  logic [7:0]       b;
  status_e          hdr_code;
  logic [37:0]      idx_need;
  logic [LW-1:0]    lvl;

  assign in_i.ready = (st_q != F_WAIT) && !cmd_full_i;
  assign acc       = in_i.valid && in_i.ready;
  assign start     = in_i.start_req;
  assign b         = in_i.data_byte;
  assign too_small = in_i.file_size < 32'(HDR_BYTES);
  assign load_en   = acc && (start ? !too_small : (st_q == F_LOAD));
  assign p         = start ? '0 : pos_q;
  assign pnext     = p + 1'b1;
  assign in_hdr    = p < POS_W'(HDR_BYTES);
  assign hdr_end   = pnext == POS_W'(HDR_BYTES);
  assign lvl       = hdr_q[10][LW-1:0];
  assign end_val   = POS_W'(HDR_BYTES) + POS_W'(lvl) * POS_W'(ENTRY_BYTES);
  assign idx_need  = 38'(HDR_BYTES) + (38'(hdr_q[10]) << 4) + (38'(hdr_q[10]) << 3);

  always_comb begin
    hdr_bad  = 1'b1;
    hdr_code = ST_OK;
    priority if ({hdr_q[2], hdr_q[1], hdr_q[0]} != MAGIC) begin
      hdr_code = ST_MAGIC;
    end else if (hdr_q[10] == '0 || hdr_q[5] == '0 || hdr_q[6] == '0) begin
      hdr_code = ST_DIMS;
    end else if (hdr_q[8] > 32'd1 || hdr_q[9] != 32'd1) begin
      hdr_code = ST_LAYOUT;
    end else if (hdr_q[11] != '0) begin
      hdr_code = ST_SUPERCOMP;
    end else if (hdr_q[3] == '0) begin
      hdr_code = ST_FORMAT;
    end else if (idx_need > 38'(size_q)) begin
      hdr_code = ST_INDEX;
    end else if (hdr_q[10] > 32'(MAX_LEVELS)) begin
      hdr_code = ST_LEVELS;
    end else begin
      hdr_bad = 1'b0;
    end
  end

  always_comb begin
    st_d       = st_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{op: CMD_ERR, code: ST_OK};
    if (acc) begin
      if (start && too_small) begin
        cmd_push_o = 1'b1;
        cmd_o      = '{op: CMD_ERR, code: ST_SMALL};
        st_d       = F_IDLE;
      end else if (load_en) begin
        st_d = F_LOAD;
        if (hdr_end) begin
          if (hdr_bad) begin
            cmd_push_o = 1'b1;
            cmd_o      = '{op: CMD_ERR, code: hdr_code};
            st_d       = F_IDLE;
          end
        end else if (pnext > POS_W'(HDR_BYTES) && pnext == end_q) begin
          cmd_push_o = 1'b1;
          cmd_o      = '{op: CMD_FINISH, code: ST_OK};
          st_d       = F_WAIT;
        end
      end else if (st_q == F_EMIT) begin
        cmd_push_o = 1'b1;
        cmd_o      = '{op: CMD_CONT, code: ST_OK};
        st_d       = F_WAIT;
      end
    end else if (st_q == F_WAIT && cmd_empty_i && stat_i.idle) begin
      st_d = stat_i.hold ? F_EMIT : F_IDLE;
    end
  end

  always_comb begin
    pos_d = pos_q;
    k_d   = k_q;
    ent_d = ent_q;
    if (load_en) begin
      pos_d = pnext;
      if (start) begin
        k_d   = '0;
        ent_d = '0;
      end else if (!in_hdr) begin
        if (k_q == KW'(ENTRY_BYTES - 1)) begin
          k_d   = '0;
          ent_d = ent_q + 1'b1;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= F_IDLE;
      pos_q <= '0;
      k_q   <= '0;
      ent_q <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      k_q   <= k_d;
      ent_q <= ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && start) begin
      size_q <= in_i.file_size;
    end
    if (load_en && in_hdr) begin
      hdr_q[p[6:2]][{p[1:0], 3'b000} +: 8] <= b;
    end
    if (load_en && !in_hdr) begin
      sh_q <= {b, sh_q[55:8]};
    end
    if (load_en && hdr_end) begin
      end_q <= end_val;
    end
  end

  assign wr_o.off_we = load_en && !in_hdr && (k_q == KW'(7));
  assign wr_o.len_we = load_en && !in_hdr && (k_q == KW'(15));
  assign wr_o.addr   = ent_q;
  assign wr_o.data   = {b, sh_q};

  assign hdr_o.size        = size_q;
  assign hdr_o.vk_format   = hdr_q[3];
  assign hdr_o.width       = hdr_q[5];
  assign hdr_o.height      = hdr_q[6];
  assign hdr_o.level_count = hdr_q[10];
  assign hdr_o.dfd_off     = hdr_q[12];
  assign hdr_o.dfd_len     = hdr_q[13];
  assign hdr_o.kvd_off     = hdr_q[14];
  assign hdr_o.kvd_len     = hdr_q[15];
  assign hdr_o.sgd_off     = {hdr_q[17], hdr_q[16]};
  assign hdr_o.sgd_len     = {hdr_q[19], hdr_q[18]};

endmodule

@@ src/tchp_back.sv @@
// Back end: data start, length ranking, footprint and bounds checks, record output.
// Holds the level offset and length memories. Depends on tchp_pkg and tchp_if.
module tchp_back #(
  parameter int unsigned MAX_LEVELS = tchp_pkg::MAX_LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tchp_pkg::cmd_t       cmd_i,
  input  logic                 cmd_empty_i,
  output logic                 cmd_pop_o,
  input  tchp_pkg::hdr_t       hdr_i,
  input  tchp_pkg::lvl_wr_t    wr_i,
  output tchp_pkg::back_stat_t stat_o,
  tchp_out_if.source           out_o
);
  import tchp_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEVELS + 1);
  localparam int unsigned IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned BW = $clog2(BATCH + 1);

  typedef enum logic [14:0] {
    B_IDLE = 15'b000000000000001,
    B_HOLD = 15'b000000000000010,
    B_ERR  = 15'b000000000000100,
    B_DS0  = 15'b000000000001000,
    B_DS1  = 15'b000000000010000,
    B_DS2  = 15'b000000000100000,
    B_DS3  = 15'b000000001000000,
    B_DS4  = 15'b000000010000000,
    B_RANK = 15'b000000100000000,
    B_CRD  = 15'b000001000000000,
    B_CMUL = 15'b000010000000000,
    B_CPRD = 15'b000100000000000,
    B_CCMP = 15'b001000000000000,
    B_ERD  = 15'b010000000000000,
    B_EWR  = 15'b100000000000000
  } bst_e;

  bst_e          st_q, st_d;
  logic [LW-1:0] m_q, m_d, i_q, i_d, j_q, j_d;
  logic [BW-1:0] batch_q, batch_d;
  logic          iss_q, iss_d, pv_q, pv_d, out_vld_q, out_vld_d;
  status_e       err_q, err_d;

  logic [63:0]   off_mem [MAX_LEVELS];
  logic [63:0]   len_mem [MAX_LEVELS];
  logic [IW-1:0] order_q [MAX_LEVELS];
  logic [63:0]   rda_off_q, rda_len_q, rdb_len_q;
  logic [IW-1:0] ra, rb;

  logic [32:0]   e1_q, e2_q, e_max;
  logic [64:0]   s_q, abs_q;
  logic [63:0]   mx_q, m0, len_q;
  logic [31:0]   ds_q, dw, dh;
  logic [LW-1:0] pi_q, pj_q, cnt_q, cnt_nx, lvl, lm1;
  logic [30:0]   bx_q, by_q;
  logic [61:0]   prod_q;
  logic [2:0]    bsh;
  logic          gt, last_pair, rnd_ovf, fp_fail, bnd_fail, slot_free, ld_err, ld_rec;

  assign lvl       = hdr_i.level_count[LW-1:0];
  assign lm1       = lvl - LW'(1);
  assign m0        = 64'(HDR_BYTES) + 64'(lvl) * 64'(ENTRY_BYTES);
  assign e_max     = (e1_q > e2_q) ? e1_q : e2_q;
  assign rnd_ovf   = (&mx_q[63:3]) && (|mx_q[2:0]);
  assign gt        = (rdb_len_q > rda_len_q) || (rdb_len_q == rda_len_q && pj_q < pi_q);
  assign cnt_nx    = cnt_q + LW'(gt);
  assign last_pair = pv_q && pj_q == lm1 && pi_q == lm1;
  assign dw        = dim_at(hdr_i.width, 5'(m_q));
  assign dh        = dim_at(hdr_i.height, 5'(m_q));
  assign bsh       = block_shift(hdr_i.vk_format);
  assign fp_fail   = (bsh != 3'd0) && ({2'b00, len_q} < (66'(prod_q) << bsh));
  assign bnd_fail  = ({1'b0, abs_q} + 66'(len_q)) > 66'(hdr_i.size);
  assign slot_free = !out_vld_q || out_o.ready;
  assign ra        = (st_q == B_RANK) ? i_q[IW-1:0] : order_q[m_q[IW-1:0]];
  assign rb        = j_q[IW-1:0];

  assign stat_o.idle = (st_q == B_IDLE) || (st_q == B_HOLD);
  assign stat_o.hold = (st_q == B_HOLD);

  always_comb begin
    st_d      = st_q;
    m_d       = m_q;
    i_d       = i_q;
    j_d       = j_q;
    batch_d   = batch_q;
    iss_d     = iss_q;
    pv_d      = 1'b0;
    err_d     = err_q;
    cmd_pop_o = 1'b0;
    ld_err    = 1'b0;
    ld_rec    = 1'b0;
    unique case (st_q)
      B_IDLE, B_HOLD: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            CMD_ERR: begin
              err_d = cmd_i.code;
              st_d  = B_ERR;
            end
            CMD_FINISH: st_d = B_DS0;
            CMD_CONT: begin
              if (st_q == B_HOLD) begin
                batch_d = '0;
                st_d    = B_ERD;
              end
            end
            default: st_d = B_IDLE;
          endcase
        end
      end
      B_ERR: begin
        if (slot_free) begin
          ld_err = 1'b1;
          st_d   = B_IDLE;
        end
      end
      B_DS0: st_d = B_DS1;
      B_DS1: begin
        if (s_q[64]) begin
          err_d = ST_DATASTART;
          st_d  = B_ERR;
        end else begin
          st_d = B_DS2;
        end
      end
      B_DS2: st_d = B_DS3;
      B_DS3: begin
        if (rnd_ovf) begin
          err_d = ST_DATASTART;
          st_d  = B_ERR;
        end else begin
          st_d = B_DS4;
        end
      end
      B_DS4: begin
        if (mx_q > 64'(hdr_i.size)) begin
          err_d = ST_DATASTART;
          st_d  = B_ERR;
        end else begin
          i_d   = '0;
          j_d   = '0;
          iss_d = 1'b1;
          st_d  = B_RANK;
        end
      end
      B_RANK: begin
        if (iss_q) begin
          pv_d = 1'b1;
          if (j_q == lm1) begin
            j_d = '0;
            i_d = i_q + 1'b1;
            if (i_q == lm1) begin
              iss_d = 1'b0;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
        if (last_pair) begin
          m_d  = '0;
          st_d = B_CRD;
        end
      end
      B_CRD:  st_d = B_CMUL;
      B_CMUL: st_d = B_CPRD;
      B_CPRD: st_d = B_CCMP;
      B_CCMP: begin
        priority if (fp_fail) begin
          err_d = ST_SHORT;
          st_d  = B_ERR;
        end else if (bnd_fail) begin
          err_d = ST_BOUNDS;
          st_d  = B_ERR;
        end else if (m_q == lm1) begin
          m_d     = '0;
          batch_d = '0;
          st_d    = B_ERD;
        end else begin
          m_d  = m_q + 1'b1;
          st_d = B_CRD;
        end
      end
      B_ERD: st_d = B_EWR;
      B_EWR: begin
        if (slot_free) begin
          ld_rec  = 1'b1;
          m_d     = m_q + 1'b1;
          batch_d = batch_q + 1'b1;
          priority if (m_q == lm1) begin
            st_d = B_IDLE;
          end else if (batch_q == BW'(BATCH - 1)) begin
            st_d = B_HOLD;
          end else begin
            st_d = B_ERD;
          end
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (ld_err || ld_rec) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= B_IDLE;
      m_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      batch_q   <= '0;
      iss_q     <= 1'b0;
      pv_q      <= 1'b0;
      out_vld_q <= 1'b0;
      err_q     <= ST_OK;
    end else begin
      st_q      <= st_d;
      m_q       <= m_d;
      i_q       <= i_d;
      j_q       <= j_d;
      batch_q   <= batch_d;
      iss_q     <= iss_d;
      pv_q      <= pv_d;
      out_vld_q <= out_vld_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.off_we) begin
      off_mem[wr_i.addr[IW-1:0]] <= wr_i.data;
    end
    if (wr_i.len_we) begin
      len_mem[wr_i.addr[IW-1:0]] <= wr_i.data;
    end
    rda_off_q <= off_mem[ra];
    rda_len_q <= len_mem[ra];
    rdb_len_q <= len_mem[rb];
  end

  always_ff @(posedge clk_i) begin
    pi_q <= i_q;
    pj_q <= j_q;
    unique case (st_q)
      B_DS0: begin
        e1_q <= {1'b0, hdr_i.dfd_off} + {1'b0, hdr_i.dfd_len};
        e2_q <= {1'b0, hdr_i.kvd_off} + {1'b0, hdr_i.kvd_len};
        s_q  <= {1'b0, hdr_i.sgd_off} + {1'b0, hdr_i.sgd_len};
      end
      B_DS1: mx_q <= (64'(e_max) > m0) ? 64'(e_max) : m0;
      B_DS2: begin
        if (s_q[63:0] > mx_q) begin
          mx_q <= s_q[63:0];
        end
      end
      B_DS3: mx_q <= {mx_q[63:3] + 61'(|mx_q[2:0]), 3'b000};
      B_DS4: begin
        ds_q  <= mx_q[31:0];
        cnt_q <= '0;
      end
      B_RANK: begin
        if (pv_q) begin
          cnt_q <= (pj_q == lm1) ? '0 : cnt_nx;
          if (pj_q == lm1) begin
            order_q[cnt_nx[IW-1:0]] <= pi_q[IW-1:0];
          end
        end
      end
      B_CMUL: begin
        bx_q  <= 31'((33'(dw) + 33'd3) >> 2);
        by_q  <= 31'((33'(dh) + 33'd3) >> 2);
        abs_q <= {1'b0, rda_off_q} + 65'(ds_q);
        len_q <= rda_len_q;
      end
      B_CPRD: prod_q <= bx_q * by_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_err) begin
      out_o.status       <= err_q;
      out_o.mip          <= '0;
      out_o.abs_offset   <= '0;
      out_o.byte_length  <= '0;
      out_o.level_width  <= '0;
      out_o.level_height <= '0;
      out_o.pixel_format <= '0;
      out_o.last         <= 1'b1;
    end else if (ld_rec) begin
      out_o.status       <= ST_OK;
      out_o.mip          <= 5'(m_q);
      out_o.abs_offset   <= ds_q + rda_off_q[31:0];
      out_o.byte_length  <= rda_len_q[31:0];
      out_o.level_width  <= dw;
      out_o.level_height <= dh;
      out_o.pixel_format <= hdr_i.vk_format;
      out_o.last         <= (m_q == lm1);
    end
  end

  assign out_o.valid = out_vld_q;

endmodule

@@ src/texture_container_header_parser_core.sv @@
// Top level of the texture container header parser.
// Depends on tchp_pkg, tchp_if, tchp_front, tchp_cmd_fifo and tchp_back.
//
// File bytes enter one per cycle while the header and level index load and
// the command queue is not full. A header error or a short file gives its
// single error record without stalling input. After the last index byte the
// input stalls while the back end works on the file: the data start, the
// ranking of the L level lengths through a two-port read of the length
// memory, the footprint and bounds checks per level, then one record out
// per level. Records leave in batches of 16; the item after a full batch
// releases the next one. Output is held in a register, so a stalled sink
// only delays the back end.
module texture_container_header_parser_core #(
  parameter int unsigned MAX_LEVELS = tchp_pkg::MAX_LEVELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tchp_in_if.sink    in_i,
  tchp_out_if.source out_o
);
  import tchp_pkg::*;

  cmd_t       push_cmd, pop_cmd;
  logic       push, pop, empty, full;
  back_stat_t stat;
  hdr_t       hdr;
  lvl_wr_t    wr;

  tchp_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_push_o  (push),
    .cmd_o       (push_cmd),
    .cmd_full_i  (full),
    .cmd_empty_i (empty),
    .stat_i      (stat),
    .hdr_o       (hdr),
    .wr_o        (wr)
  );

  tchp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  tchp_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .cmd_empty_i (empty),
    .cmd_pop_o   (pop),
    .hdr_i       (hdr),
    .wr_i        (wr),
    .stat_o      (stat),
    .out_o       (out_o)
  );

endmodule
